// ===== design/scgs_pkg.sv =====
// ----------------------------------------------------------------------------
// scgs_pkg
// Shared types and constants for the start code group splitter.
// ----------------------------------------------------------------------------
package scgs_pkg;

  localparam int FIELD_BITS = 24;
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = 24'hFFFFFF;

  // result queue depth, power of two and at least two
  localparam int RES_FIFO_DEPTH = 4;

  localparam logic [7:0] SC_LAST_BYTE = 8'h01;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_FIRST  = 2'd1,
    PH_GROUP  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                  found;
    logic [3:0]            unit_type;
    logic [FIELD_BITS-1:0] payload_start;
    logic [FIELD_BITS-1:0] payload_size;
    logic [FIELD_BITS-1:0] bytes_consumed;
    logic                  final_res;
  } result_t;

  // two push lanes into the result queue, lane a first
  typedef struct packed {
    logic push_a;
    logic push_b;
    logic pop;
  } fifo_ctrl_t;

endpackage

// ===== design/scgs_res_fifo.sv =====
// ----------------------------------------------------------------------------
// scgs_res_fifo
// Small result queue taking up to two words per cycle and giving one.
// ----------------------------------------------------------------------------
module scgs_res_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  scgs_pkg::fifo_ctrl_t          ctrl,
  input  scgs_pkg::result_t             data_a,
  input  scgs_pkg::result_t             data_b,
  output scgs_pkg::result_t             head,
  output logic [$clog2(DEPTH):0]        count
);

  localparam int AW = $clog2(DEPTH);

  scgs_pkg::result_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW-1:0] wr_ptr_b;
  logic [AW:0]   count_next;

  assign wr_ptr_b = ctrl.push_a ? wr_ptr + AW'(1) : wr_ptr;
  assign head     = entries[rd_ptr];

  always_comb begin
    count_next = count + (AW+1)'(ctrl.push_a) + (AW+1)'(ctrl.push_b)
                 - (AW+1)'(ctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(ctrl.push_a) + AW'(ctrl.push_b);
      rd_ptr <= rd_ptr + AW'(ctrl.pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_a) entries[wr_ptr] <= data_a;
    if (ctrl.push_b) entries[wr_ptr_b] <= data_b;
  end

endmodule

// ===== design/start_code_nal_group_splitter_core.sv =====
// ----------------------------------------------------------------------------
// start_code_nal_group_splitter_core
// Splits a byte stream at 00 00 00 01 start codes and merges units of equal
// type into groups, reporting type, start, size and consumed count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  byte      in         byte_valid / byte_stall   data_byte, buffer_end
//  result    out        res_valid / res_stall     found .. final_res
//  config    in         start_offset_we           start_offset_wdata
//
//  one byte per cycle; each byte is handled in the cycle it is taken and its
//  results sit in a four-word queue, visible from the next cycle on
//  byte_stall rises when the queue has room for fewer than two words, so the
//  rate drops only while res_stall lets results pile up in the queue
//  rst is synchronous and clears the scan state, queue and start offset
// ----------------------------------------------------------------------------
module start_code_nal_group_splitter_core #(
  parameter int POSITION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        found,
  output logic [3:0]  unit_type,
  output logic [23:0] payload_start,
  output logic [23:0] payload_size,
  output logic [23:0] bytes_consumed,
  output logic        final_res,
  input  logic        start_offset_we,
  input  logic [23:0] start_offset_wdata
);

  localparam int FB = scgs_pkg::FIELD_BITS;
  localparam int XW = ((POSITION_BITS > FB) ? POSITION_BITS : FB) + 2;
  localparam int DEPTH = scgs_pkg::RES_FIFO_DEPTH;
  localparam logic [XW-1:0] POS_MAX_X = XW'((64'd1 << POSITION_BITS) - 64'd1);
  localparam logic [XW-1:0] FIELD_MAX_X = XW'(scgs_pkg::FIELD_MAX);

  function automatic logic [XW-1:0] sat_pos(input logic [XW-1:0] v);
    return (v > POS_MAX_X) ? POS_MAX_X : v;
  endfunction

  function automatic logic [FB-1:0] sat_field(input logic [XW-1:0] v);
    return (v > FIELD_MAX_X) ? scgs_pkg::FIELD_MAX : v[FB-1:0];
  endfunction

  // scan state
  logic [23:0]              recent_bytes, recent_bytes_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  scgs_pkg::phase_t         scan_phase, scan_phase_next, phase_mid;
  logic [3:0]               group_type, group_type_next;
  logic [POSITION_BITS-1:0] group_start, group_start_next;
  logic                     awaiting_type, awaiting_type_next, awaiting_mid;
  logic [23:0]              start_offset;

  logic                     accept;
  logic [3:0]               byte_type;
  logic                     window_hit;
  logic                     close_hit;
  logic [XW-1:0]            pos_x, gs_old_x, gs_mid_x, off_x, sc_x, endp_x;
  logic [XW-1:0]            close_size_x, last_size_x, last_start_x;
  scgs_pkg::result_t        close_res, last_res, head;
  scgs_pkg::fifo_ctrl_t     fctrl;
  logic [$clog2(DEPTH):0]   count;

  assign byte_stall = count > ($clog2(DEPTH)+1)'(DEPTH - 2);
  assign accept     = byte_valid && !byte_stall;
  assign byte_type  = data_byte[5:2];
  assign window_hit = (recent_bytes == 24'h000000) && (data_byte == scgs_pkg::SC_LAST_BYTE);

  assign pos_x    = XW'(byte_position);
  assign gs_old_x = XW'(group_start);
  assign off_x    = XW'(start_offset);
  assign sc_x     = (pos_x >= XW'(4)) ? pos_x - XW'(4) : '0;
  assign endp_x   = pos_x + XW'(1);

  always_comb begin
    phase_mid          = scan_phase;
    group_type_next    = group_type;
    group_start_next   = group_start;
    awaiting_mid       = awaiting_type;
    close_hit          = 1'b0;

    case (scan_phase)
      scgs_pkg::PH_FIRST: begin
        group_type_next  = byte_type;
        group_start_next = byte_position;
        phase_mid        = scgs_pkg::PH_GROUP;
      end
      scgs_pkg::PH_GROUP: begin
        if (awaiting_type) begin
          awaiting_mid = 1'b0;
          if (byte_type != group_type) begin
            close_hit        = 1'b1;
            group_type_next  = byte_type;
            group_start_next = byte_position;
          end
        end
      end
      default: ;
    endcase

    if (window_hit) begin
      if (phase_mid == scgs_pkg::PH_SEARCH) phase_mid = scgs_pkg::PH_FIRST;
      else if (phase_mid == scgs_pkg::PH_GROUP) awaiting_mid = 1'b1;
    end

    if (buffer_end) begin
      recent_bytes_next  = 24'hFFFFFF;
      byte_position_next = '0;
      scan_phase_next    = scgs_pkg::PH_SEARCH;
      awaiting_type_next = 1'b0;
    end else begin
      recent_bytes_next  = {recent_bytes[15:0], data_byte};
      byte_position_next = POSITION_BITS'(sat_pos(endp_x));
      scan_phase_next    = phase_mid;
      awaiting_type_next = awaiting_mid;
    end
  end

  // closed group on a type change
  assign close_size_x = (sc_x > gs_old_x) ? sc_x - gs_old_x : '0;
  always_comb begin
    close_res.found          = 1'b1;
    close_res.unit_type      = group_type;
    close_res.payload_start  = sat_field(sat_pos(off_x + gs_old_x));
    close_res.payload_size   = sat_field(close_size_x);
    close_res.bytes_consumed = sat_field(sc_x);
    close_res.final_res      = 1'b0;
  end

  // group still open at the buffer's last byte
  assign gs_mid_x     = XW'(group_start_next);
  assign last_size_x  = (endp_x > gs_mid_x) ? endp_x - gs_mid_x : '0;
  assign last_start_x = (phase_mid == scgs_pkg::PH_FIRST) ? endp_x : gs_mid_x;
  always_comb begin
    last_res.final_res = 1'b1;
    case (phase_mid)
      scgs_pkg::PH_SEARCH: begin
        last_res.found          = 1'b0;
        last_res.unit_type      = '0;
        last_res.payload_start  = '0;
        last_res.payload_size   = '0;
        last_res.bytes_consumed = '0;
      end
      scgs_pkg::PH_FIRST: begin
        last_res.found          = 1'b1;
        last_res.unit_type      = '0;
        last_res.payload_start  = sat_field(sat_pos(off_x + last_start_x));
        last_res.payload_size   = '0;
        last_res.bytes_consumed = sat_field(endp_x);
      end
      default: begin
        last_res.found          = 1'b1;
        last_res.unit_type      = group_type_next;
        last_res.payload_start  = sat_field(sat_pos(off_x + last_start_x));
        last_res.payload_size   = sat_field(last_size_x);
        last_res.bytes_consumed = sat_field(endp_x);
      end
    endcase
  end

  assign fctrl.push_a = accept && close_hit;
  assign fctrl.push_b = accept && buffer_end;
  assign fctrl.pop    = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes  <= 24'hFFFFFF;
      byte_position <= '0;
      scan_phase    <= scgs_pkg::PH_SEARCH;
      group_type    <= '0;
      group_start   <= '0;
      awaiting_type <= 1'b0;
    end else if (accept) begin
      recent_bytes  <= recent_bytes_next;
      byte_position <= byte_position_next;
      scan_phase    <= scan_phase_next;
      group_type    <= buffer_end ? 4'd0 : group_type_next;
      group_start   <= buffer_end ? '0 : group_start_next;
      awaiting_type <= awaiting_type_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
    end else if (start_offset_we) begin
      start_offset <= start_offset_wdata;
    end
  end

  scgs_res_fifo #(
    .DEPTH (DEPTH)
  ) u_res_fifo (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (fctrl),
    .data_a (close_res),
    .data_b (last_res),
    .head   (head),
    .count  (count)
  );

  assign res_valid      = count != '0;
  assign found          = head.found;
  assign unit_type      = head.unit_type;
  assign payload_start  = head.payload_start;
  assign payload_size   = head.payload_size;
  assign bytes_consumed = head.bytes_consumed;
  assign final_res      = head.final_res;

endmodule

// ===== design/scgs_checker.sv =====
// ----------------------------------------------------------------------------
// scgs_checker
// Port-level checks for the start code group splitter, bound to the top.
// ----------------------------------------------------------------------------
module scgs_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic        found,
  input logic [3:0]  unit_type,
  input logic [23:0] payload_start,
  input logic [23:0] payload_size,
  input logic [23:0] bytes_consumed,
  input logic        final_res
);

  // a held result word stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(payload_start)
      && $stable(payload_size) && $stable(bytes_consumed))
    else $error("held result word changed");

  a_res_hold_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(found) && $stable(unit_type) && $stable(final_res))
    else $error("held result flags changed");

  // report for a buffer with no start code carries nothing but the final mark
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> final_res && unit_type == 4'd0 && payload_start == 24'd0
      && payload_size == 24'd0 && bytes_consumed == 24'd0)
    else $error("not-found result with non-zero fields");

  // queue is empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && !byte_stall)
    else $error("result pending after reset");

endmodule

bind start_code_nal_group_splitter_core scgs_checker u_scgs_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds byte buffers into the start code group splitter and checks every
// result word against a cycle-free prediction of the grouping rules: directed
// corner buffers first, then random well-formed and broken Annex-B buffers
// under several start offsets, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_AT     = 500;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int ITEMS_PER_PHASE  = 240;
  localparam int DRAIN_CYCLES     = 6;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        buffer_end = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        found;
  logic [3:0]  unit_type;
  logic [23:0] payload_start;
  logic [23:0] payload_size;
  logic [23:0] bytes_consumed;
  logic        final_res;
  logic        start_offset_we = 1'b0;
  logic [23:0] start_offset_wdata = 24'h0;

  start_code_nal_group_splitter_core #(
    .POSITION_BITS(24)
  ) u_top (
    .clk               (clk),
    .rst               (rst),
    .byte_valid        (byte_valid),
    .byte_stall        (byte_stall),
    .data_byte         (data_byte),
    .buffer_end        (buffer_end),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .found             (found),
    .unit_type         (unit_type),
    .payload_start     (payload_start),
    .payload_size      (payload_size),
    .bytes_consumed    (bytes_consumed),
    .final_res         (final_res),
    .start_offset_we   (start_offset_we),
    .start_offset_wdata(start_offset_wdata)
  );

  stream_byte_t        bytes_to_send[$];
  scgs_pkg::result_t   groups_due[$];
  stream_byte_t        next_byte;
  scgs_pkg::result_t   got_group;
  scgs_pkg::result_t   want_group;

  int err_cnt     = 0;
  int items_made  = 0;
  int bytes_taken = 0;
  int idle_odds   = 6;
  int gap_left    = 0;
  int hold_left   = 0;
  bit long_hold_done = 1'b0;
  bit byte_taken     = 1'b0;

  // predicted splitter state
  logic [23:0]       cfg_offset = 24'h0;
  logic [23:0]       tail3      = 24'hFFFFFF;
  logic [23:0]       byte_pos   = 24'h0;
  scgs_pkg::phase_t  scan_ph    = scgs_pkg::PH_SEARCH;
  logic [3:0]        grp_type   = 4'h0;
  logic [23:0]       grp_start  = 24'h0;
  logic              await_type = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [23:0] sat24(input logic [25:0] v);
    return (v > {2'b00, scgs_pkg::FIELD_MAX}) ? scgs_pkg::FIELD_MAX : v[23:0];
  endfunction

  function automatic void push_group(input logic fnd, input logic [3:0] typ,
                                     input logic [24:0] start_rel,
                                     input logic [24:0] size,
                                     input logic [24:0] cons, input logic fin);
    scgs_pkg::result_t r;
    r.found          = fnd;
    r.unit_type      = typ;
    r.payload_start  = fnd ? sat24({2'b00, cfg_offset} + {1'b0, start_rel}) : '0;
    r.payload_size   = sat24({1'b0, size});
    r.bytes_consumed = sat24({1'b0, cons});
    r.final_res      = fin;
    groups_due.push_back(r);
  endfunction

  function automatic void split_byte(input logic [7:0] b, input logic last);
    logic [3:0]  t;
    logic [24:0] p;
    logic [24:0] sc;
    logic [24:0] endp;
    t    = b[5:2];
    p    = {1'b0, byte_pos};
    endp = p + 25'd1;
    if (scan_ph == scgs_pkg::PH_FIRST) begin
      grp_type  = t;
      grp_start = byte_pos;
      scan_ph   = scgs_pkg::PH_GROUP;
    end else if (scan_ph == scgs_pkg::PH_GROUP && await_type) begin
      await_type = 1'b0;
      if (t != grp_type) begin
        sc = (p >= 25'd4) ? p - 25'd4 : 25'd0;
        push_group(1'b1, grp_type, {1'b0, grp_start},
                   (sc > {1'b0, grp_start}) ? sc - {1'b0, grp_start} : 25'd0,
                   sc, 1'b0);
        grp_type  = t;
        grp_start = byte_pos;
      end
    end
    // sliding window, so a code can overlap the type byte before it
    if (tail3 == 24'h0 && b == scgs_pkg::SC_LAST_BYTE) begin
      if (scan_ph == scgs_pkg::PH_SEARCH) scan_ph = scgs_pkg::PH_FIRST;
      else if (scan_ph == scgs_pkg::PH_GROUP) await_type = 1'b1;
    end
    tail3 = {tail3[15:0], b};
    if (last) begin
      case (scan_ph)
        scgs_pkg::PH_SEARCH: push_group(1'b0, 4'h0, 25'd0, 25'd0, 25'd0, 1'b1);
        scgs_pkg::PH_FIRST:  push_group(1'b1, 4'h0, endp, 25'd0, endp, 1'b1);
        default: begin
          push_group(1'b1, grp_type, {1'b0, grp_start},
                     (endp > {1'b0, grp_start}) ? endp - {1'b0, grp_start} : 25'd0,
                     endp, 1'b1);
        end
      endcase
      tail3      = 24'hFFFFFF;
      byte_pos   = 24'h0;
      scan_ph    = scgs_pkg::PH_SEARCH;
      grp_type   = 4'h0;
      grp_start  = 24'h0;
      await_type = 1'b0;
    end else begin
      byte_pos = sat24({2'b00, byte_pos} + 26'd1);
    end
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // byte side: present a new byte once the last one has gone
  always @(negedge clk) begin
    if (!byte_valid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        gap_left = $urandom_range(1, 4) - 1;
        byte_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        next_byte = bytes_to_send.pop_front();
        byte_valid <= 1'b1;
        data_byte  <= next_byte.value;
        buffer_end <= next_byte.last;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // result side: short random stalls plus one long hold-off to fill the queue
  always @(negedge clk) begin
    if (!long_hold_done && bytes_taken >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      hold_left = $urandom_range(1, 4) - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    byte_taken = !rst && byte_valid && !byte_stall;
    if (!rst && start_offset_we) cfg_offset = start_offset_wdata;
    if (byte_taken) begin
      split_byte(data_byte, buffer_end);
      bytes_taken++;
    end
    if (!rst && res_valid && !res_stall) begin
      got_group = '{found, unit_type, payload_start, payload_size, bytes_consumed,
                    final_res};
      if (groups_due.size() == 0) begin
        $error("result word with nothing expected: %p", got_group);
        err_cnt++;
      end else begin
        want_group = groups_due.pop_front();
        check_field("found", 24'(want_group.found), 24'(got_group.found));
        check_field("unit_type", 24'(want_group.unit_type), 24'(got_group.unit_type));
        check_field("payload_start", want_group.payload_start, got_group.payload_start);
        check_field("payload_size", want_group.payload_size, got_group.payload_size);
        check_field("bytes_consumed", want_group.bytes_consumed,
                    got_group.bytes_consumed);
        check_field("final_res", 24'(want_group.final_res), 24'(got_group.final_res));
      end
    end
  end

  initial begin : watchdog
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  task automatic add_byte(input logic [7:0] v);
    stream_byte_t s;
    s.value = v;
    s.last  = 1'b0;
    bytes_to_send.push_back(s);
    items_made++;
  endtask

  task automatic close_buffer();
    bytes_to_send[bytes_to_send.size() - 1].last = 1'b1;
  endtask

  task automatic add_start_code();
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(scgs_pkg::SC_LAST_BYTE);
  endtask

  function automatic logic [7:0] noise_byte();
    return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  task automatic add_random_buffer();
    int         units;
    int         plen;
    int         first;
    logic [3:0] ty;
    logic [7:0] v;
    first = bytes_to_send.size();
    units = $urandom_range(0, 4);
    ty    = 4'($urandom);
    repeat ($urandom_range(0, 3)) add_byte(noise_byte());
    for (int u = 0; u < units; u++) begin
      if ($urandom_range(0, 9) == 0) begin
        // broken code, three bytes only
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'($urandom_range(0, 2)));
      end else begin
        add_start_code();
      end
      if (u == units - 1 && $urandom_range(0, 5) == 0) break;
      if ($urandom_range(0, 2) == 0) ty = 4'($urandom);
      v = 8'($urandom);
      v[5:2] = ty;
      add_byte(v);
      plen = (u == units - 1 && $urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
      repeat (plen) add_byte(noise_byte());
    end
    if (bytes_to_send.size() == first) add_byte(noise_byte());
    close_buffer();
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || byte_valid || groups_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_offset(input logic [23:0] v);
    wait_drained();
    start_offset_we    <= 1'b1;
    start_offset_wdata <= v;
    @(negedge clk);
    start_offset_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [23:0] off;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_offset(24'h0);
    // no start code at all
    add_byte(8'hFF);
    close_buffer();
    // start code on the last byte, type byte missing
    add_start_code();
    close_buffer();
    // start code ending exactly at the buffer end inside a group
    add_start_code();
    add_byte(8'hFC);
    add_start_code();
    close_buffer();
    // overlapping codes, merge of equal types, type change on the last byte
    add_start_code();
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(scgs_pkg::SC_LAST_BYTE);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(scgs_pkg::SC_LAST_BYTE);
    add_byte(8'h3C);
    close_buffer();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1:       off = scgs_pkg::FIELD_MAX;
        2:       off = scgs_pkg::FIELD_MAX - 24'd20;
        5:       off = 24'h0;
        default: off = 24'($urandom);
      endcase
      write_offset(off);
      // phase 3 runs without idling, the last one too
      idle_odds = (ph == 3 || ph == 6) ? 0 : ((ph == 4) ? 3 : 6);
      while (items_made < ph * ITEMS_PER_PHASE) add_random_buffer();
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/scgs_pkg.sv
design/scgs_res_fifo.sv
design/start_code_nal_group_splitter_core.sv
design/scgs_checker.sv
dv/tb_top.sv
